FILE: rtl/aes128_keystream_xor_unit_macros.svh
// Assertion macros for the AES-128 keystream unit.
`ifndef AES128_KEYSTREAM_XOR_UNIT_MACROS_SVH
`define AES128_KEYSTREAM_XOR_UNIT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define AKX_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define AKX_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

FILE: rtl/akx_pkg.sv
// Package: AES constants, S-box and small byte functions.
package akx_pkg;
   localparam int unsigned BlockBytes = 16;
   localparam int unsigned NumRounds = 10;
   localparam logic [0:0] CSR_KEY_UPPER = 1'b0;
   localparam logic [0:0] CSR_KEY_LOWER = 1'b1;

   typedef logic [7:0] byte_type;
   typedef logic [127:0] block_type;

   function automatic byte_type sbox(input byte_type x);
      byte_type r;
      case (x)
         8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
         8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
         8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
         8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
         8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
         8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
         8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
         8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
         8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
         8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
         8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
         8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
         8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
         8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
         8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
         8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
         8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
         8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
         8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
         8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
         8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
         8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
         8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
         8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
         8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
         8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
         8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
         8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
         8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
         8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
         8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
         8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
         8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
         8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
         8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
         8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
         8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
         8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
         8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
         8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
         8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
         8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
         8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
         8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
         8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
         8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
         8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
         8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
         8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
         8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
         8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
         8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
         8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
         8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
         8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
         8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
         8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
         8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
         8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
         8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
         8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
         8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
         8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
         8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic byte_type xtime(input byte_type x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   // Byte i of a packed block; byte 0 sits in the top bits.
   function automatic byte_type blk_byte(input block_type b, input int unsigned i);
      return b[127 - 8*i -: 8];
   endfunction
endpackage

FILE: rtl/akx_stream_if.sv
// Valid/ready channel interfaces for the keystream unit.
interface akx_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       message_start;
   modport source (output valid, data_byte, message_start, input ready);
   modport sink (input valid, data_byte, message_start, output ready);
endinterface

interface akx_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] result_byte;
   modport source (output valid, result_byte, input ready);
   modport sink (input valid, result_byte, output ready);
endinterface

interface akx_csr_if;
   logic        valid;
   logic        ready;
   logic [63:0] index;
   logic [63:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/aes128_keystream_xor_unit.sv
// Top level: AES-128 OFB keystream XOR unit with iterative round engine.
// Usage:
//  - csr channel writes the key: index 0 = key bytes 0..7, index 1 = bytes 8..15.
//    Always ready; write only while the unit is idle.
//  - req channel takes one byte plus a message_start flag; rsp returns the byte
//    XORed with the current keystream byte, one result per item, in order.
//  - Item at a block boundary (position 0) or with message_start set runs a
//    full AES-128 encryption: 10 rounds on the shared round unit, with
//    round keys computed on the fly beside the state. Its result is registered
//    after the last round; any other item's result is valid in the cycle after accept.
//  - A new item is taken only once the previous result has left, so the unit
//    never starts on an item before it is through with the last one; the ten
//    round passes make a boundary item slower than any other.
//  - Result is held in an output register; req is not ready while it waits, so
//    a stalled receiver stalls the sender.
//  - Reset (synchronous, high) clears key, keystream block and position; a
//    first byte without start then yields the zero-block keystream.
//  - No round key store: the schedule is regenerated on each encryption.
module aes128_keystream_xor_unit
   import akx_pkg::*;
(
   input logic      clock,
   input logic      reset,
   akx_req_if.sink  req,
   akx_rsp_if.source rsp,
   akx_csr_if.sink  csr
);
`include "aes128_keystream_xor_unit_macros.svh"

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_OUT  = 2'd2;

   logic [1:0]  state_ff, state_in;
   logic [63:0] key_hi_ff, key_lo_ff;
   block_type   ks_ff, ks_in;       // keystream block
   block_type   rk_ff, rk_in;       // running round key
   logic [3:0]  pos_ff, pos_in;
   logic [3:0]  rnd_ff, rnd_in;     // round 1..10
   byte_type    rcon_ff, rcon_in;
   byte_type    data_ff, data_in;
   byte_type    res_ff, res_in;
   block_type   ru_state, ru_key;
   block_type   key_blk;
   logic        req_fire;

   assign key_blk  = {key_hi_ff, key_lo_ff};
   assign req.ready = (state_ff == ST_IDLE);
   assign req_fire  = req.valid && req.ready;
   assign csr.ready = 1'b1;
   assign rsp.valid = (state_ff == ST_OUT);
   assign rsp.result_byte = res_ff;

   akx_round_unit u_round (
      .state_i (ks_ff),
      .rkey_i  (rk_ff),
      .last_i  (rnd_ff == 4'(NumRounds)),
      .rcon_i  (rcon_ff),
      .state_o (ru_state),
      .rkey_o  (ru_key)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         key_hi_ff <= '0;
         key_lo_ff <= '0;
      end else if (csr.valid) begin
         if (csr.index == 64'(CSR_KEY_UPPER)) key_hi_ff <= csr.data;
         if (csr.index == 64'(CSR_KEY_LOWER)) key_lo_ff <= csr.data;
      end
   end

   always_comb begin
      state_in = state_ff;
      ks_in    = ks_ff;
      rk_in    = rk_ff;
      pos_in   = pos_ff;
      rnd_in   = rnd_ff;
      rcon_in  = rcon_ff;
      data_in  = data_ff;
      res_in   = res_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               data_in = req.data_byte;
               if (req.message_start || pos_ff == 4'd0) begin
                  // whitening with round key 0, then iterate
                  ks_in    = (req.message_start ? '0 : ks_ff) ^ key_blk;
                  pos_in   = 4'd0;
                  rk_in    = key_blk;
                  rnd_in   = 4'd1;
                  rcon_in  = 8'h01;
                  state_in = ST_RUN;
               end else begin
                  res_in   = req.data_byte ^ blk_byte(ks_ff, 32'(pos_ff));
                  pos_in   = pos_ff + 4'd1;
                  state_in = ST_OUT;
               end
            end
         end
         ST_RUN: begin
            ks_in   = ru_state;
            rk_in   = ru_key;
            rnd_in  = rnd_ff + 4'd1;
            rcon_in = xtime(rcon_ff);
            if (rnd_ff == 4'(NumRounds)) begin
               res_in   = data_ff ^ ru_state[127:120];
               pos_in   = 4'd1;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp.ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ks_ff    <= '0;
         pos_ff   <= '0;
         rnd_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ks_ff    <= ks_in;
         pos_ff   <= pos_in;
         rnd_ff   <= rnd_in;
      end
   end

   always_ff @(posedge clock) begin
      rk_ff   <= rk_in;
      rcon_ff <= rcon_in;
      data_ff <= data_in;
      res_ff  <= res_in;
   end

   `AKX_ASSERT_IMPL(a_round_range, clock, reset, state_ff == ST_RUN,
      rnd_ff >= 4'd1 && rnd_ff <= 4'(NumRounds), "round count out of range")
   `AKX_ASSERT_NEXT(a_last_round_out, clock, reset,
      state_ff == ST_RUN && rnd_ff == 4'(NumRounds),
      state_ff == ST_OUT && pos_ff == 4'd1, "last round did not deliver result")
   `AKX_ASSERT_NEXT(a_hold_result, clock, reset, rsp.valid && !rsp.ready,
      rsp.valid && $stable(res_ff), "stalled result changed")
endmodule

FILE: rtl/akx_round_unit.sv
// Shared AES round datapath: one cipher round plus one key schedule step per cycle.
module akx_round_unit
   import akx_pkg::*;
(
   input  block_type state_i,
   input  block_type rkey_i,
   input  logic      last_i,
   input  byte_type  rcon_i,
   output block_type state_o,
   output block_type rkey_o
);
   block_type sh;
   block_type mx;
   byte_type  t0, t1, t2, t3;
   byte_type  a, b, c, d;

   // SubBytes + ShiftRows, then MixColumns unless final round
   always_comb begin
      sh = '0;
      mx = '0;
      for (int col = 0; col < 4; col++) begin
         for (int row = 0; row < 4; row++) begin
            sh[127 - 8*(4*col+row) -: 8] =
               sbox(blk_byte(state_i, 4*((col+row) % 4) + row));
         end
      end
      for (int col = 0; col < 4; col++) begin
         a = blk_byte(sh, 4*col);
         b = blk_byte(sh, 4*col+1);
         c = blk_byte(sh, 4*col+2);
         d = blk_byte(sh, 4*col+3);
         mx[127 - 8*(4*col)   -: 8] = xtime(a) ^ xtime(b) ^ b ^ c ^ d;
         mx[127 - 8*(4*col+1) -: 8] = a ^ xtime(b) ^ xtime(c) ^ c ^ d;
         mx[127 - 8*(4*col+2) -: 8] = a ^ b ^ xtime(c) ^ xtime(d) ^ d;
         mx[127 - 8*(4*col+3) -: 8] = xtime(a) ^ a ^ b ^ c ^ xtime(d);
      end
   end

   // next round key from current one
   always_comb begin
      t0 = sbox(blk_byte(rkey_i, 13)) ^ rcon_i;
      t1 = sbox(blk_byte(rkey_i, 14));
      t2 = sbox(blk_byte(rkey_i, 15));
      t3 = sbox(blk_byte(rkey_i, 12));
      rkey_o[127:96] = rkey_i[127:96] ^ {t0, t1, t2, t3};
      rkey_o[95:64]  = rkey_i[95:64] ^ rkey_o[127:96];
      rkey_o[63:32]  = rkey_i[63:32] ^ rkey_o[95:64];
      rkey_o[31:0]   = rkey_i[31:0] ^ rkey_o[63:32];
   end

   assign state_o = (last_i ? sh : mx) ^ rkey_o;
endmodule
